// ===== hw/rtl/spmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_pkg
// Shared types, constants and tables of the person mask filter.
// ----------------------------------------------------------------------------
package spmf_pkg;

   localparam int MAX_PERSONS_DEF  = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;

   localparam logic [31:0] CORDIC_INV_GAIN = 32'h26DD3B6A;

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;

   localparam logic [2:0] CSR_RANGE_LOWER = 3'd0;
   localparam logic [2:0] CSR_RANGE_UPPER = 3'd1;
   localparam logic [2:0] CSR_ANGLE_START = 3'd2;
   localparam logic [2:0] CSR_ANGLE_STEP  = 3'd3;
   localparam logic [2:0] CSR_MASK_RADIUS = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_CORDIC,
      ST_PROJECT,
      ST_SCAN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request item
      logic angle;       // form angle
      logic cordic_init; // start rotation
      logic cordic_step; // one rotation step
      logic project;     // scale cos/sin by range
      logic scan_step;   // compare one person
      logic finish;      // write result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_bounds;
      logic cordic_last;
      logic scan_last;
      logic scan_empty;
   } status_type;

   function automatic logic [31:0] atan_lut(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051D;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F;
         5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B;
         5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2;
         5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/scan_person_mask_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_person_mask_filter
// Masks range samples that fall within a radius of a tracked person.
// ----------------------------------------------------------------------------
// Sequence: clear/append update the table when accepted; a sample forms its
// angle, runs the shared rotation unit, projects the range and scans the table
// one person per cycle. Out-of-bounds samples skip rotation and scan.
// Throughput: one item at a time; the next item is accepted once the result is
// registered, which waits while an earlier result is held for rsp_tready.
// Synchronous reset restores CSR defaults and empties the person table.
module scan_person_mask_filter #(
   parameter int MAX_PERSONS  = spmf_pkg::MAX_PERSONS_DEF,
   parameter int CORDIC_STEPS = spmf_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[1:0], person_x[19:2], person_y[37:20], range_value[53:38],
   // range_invalid[54], sample_index[66:55]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // range_out[15:0], range_invalid_out[16], masked[17], sample_index_out[29:18]
   output logic [31:0] rsp_tdata
);
   import spmf_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       table_clear, table_append;
   logic [15:0] r_out;
   logic        r_inv, r_mask;
   logic [11:0] r_idx;

   spmf_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_func(req_tdata[1:0]), .rsp_tvalid, .rsp_tready,
      .status, .cmd, .table_clear, .table_append
   );

   spmf_datapath #(.MAX_PERSONS(MAX_PERSONS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_person_x(req_tdata[19:2]), .req_person_y(req_tdata[37:20]),
      .req_range_value(req_tdata[53:38]), .req_range_invalid(req_tdata[54]),
      .req_sample_index(req_tdata[66:55]),
      .table_clear, .table_append, .cmd, .status,
      .rsp_range_out(r_out), .rsp_range_invalid_out(r_inv),
      .rsp_masked(r_mask), .rsp_sample_index_out(r_idx)
   );

   assign rsp_tdata = {2'b00, r_idx, r_mask, r_inv, r_out};
endmodule

// ===== hw/rtl/spmf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_ctrl
// Sequencer: accepts items, steps the datapath, hands off results.
// ----------------------------------------------------------------------------
module spmf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_func,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  spmf_pkg::status_type status,
   output spmf_pkg::cmd_type   cmd,
   output logic                table_clear,
   output logic                table_append
);
   import spmf_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign table_clear  = accept && (req_func == FUNC_CLEAR);
   assign table_append = accept && (req_func == FUNC_APPEND);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept && req_func == FUNC_SAMPLE) state_in = ST_ANGLE;
         ST_ANGLE:   begin
            if (status.in_bounds) state_in = ST_CORDIC;
            else state_in = ST_DONE;
         end
         ST_CORDIC:  if (status.cordic_last) state_in = ST_PROJECT;
         ST_PROJECT: begin
            if (status.scan_empty) state_in = ST_DONE;
            else state_in = ST_SCAN;
         end
         ST_SCAN:    if (status.scan_last) state_in = ST_DONE;
         ST_DONE:    if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.load = accept;
      unique case (state_ff)
         ST_IDLE:    ;
         ST_ANGLE:   begin
            cmd.angle       = 1'b1;
            cmd.cordic_init = 1'b1;
         end
         ST_CORDIC:  cmd.cordic_step = 1'b1;
         ST_PROJECT: cmd.project = 1'b1;
         ST_SCAN:    cmd.scan_step = 1'b1;
         ST_DONE:    cmd.finish = !rsp_valid_ff || rsp_tready;
         default:    ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_finish_done: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finish lost result");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !cmd.finish)
      else $error("result overwritten");
endmodule

// ===== hw/rtl/spmf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_datapath
// Registers, person table, angle, iterative rotation and distance scan.
// ----------------------------------------------------------------------------
module spmf_datapath #(
   parameter int MAX_PERSONS  = spmf_pkg::MAX_PERSONS_DEF,
   parameter int CORDIC_STEPS = spmf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  logic signed [17:0]   req_person_x,
   input  logic signed [17:0]   req_person_y,
   input  logic [15:0]          req_range_value,
   input  logic                 req_range_invalid,
   input  logic [11:0]          req_sample_index,
   input  logic                 table_clear,
   input  logic                 table_append,
   input  spmf_pkg::cmd_type    cmd,
   output spmf_pkg::status_type status,
   output logic [15:0]          rsp_range_out,
   output logic                 rsp_range_invalid_out,
   output logic                 rsp_masked,
   output logic [11:0]          rsp_sample_index_out
);
   import spmf_pkg::*;

   localparam int PW = $clog2(MAX_PERSONS + 1);
   localparam int AW = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1;

   logic [15:0] range_lower_ff, range_upper_ff, angle_start_ff, angle_step_ff;
   logic [15:0] mask_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_lower_ff <= 16'd0;
         range_upper_ff <= 16'hFFFF;
         angle_start_ff <= 16'd0;
         angle_step_ff  <= 16'd0;
         mask_radius_ff <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RANGE_LOWER: range_lower_ff <= csr_wdata;
            CSR_RANGE_UPPER: range_upper_ff <= csr_wdata;
            CSR_ANGLE_START: angle_start_ff <= csr_wdata;
            CSR_ANGLE_STEP:  angle_step_ff  <= csr_wdata;
            CSR_MASK_RADIUS: mask_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // person table
   logic signed [17:0] px_mem [MAX_PERSONS];
   logic signed [17:0] py_mem [MAX_PERSONS];
   logic [PW-1:0]      count_ff;
   logic signed [17:0] px_rd_ff, py_rd_ff;
   logic [AW-1:0]      rd_addr;
   logic [PW-1:0]      scan_ff, scan_in;

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (table_clear) count_ff <= '0;
      else if (table_append && count_ff < PW'(MAX_PERSONS))
         count_ff <= count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (table_append && count_ff < PW'(MAX_PERSONS)) begin
         px_mem[count_ff[AW-1:0]] <= req_person_x;
         py_mem[count_ff[AW-1:0]] <= req_person_y;
      end
   end

   assign rd_addr = scan_in[AW-1:0];
   always_ff @(posedge clock) begin
      px_rd_ff <= px_mem[rd_addr];
      py_rd_ff <= py_mem[rd_addr];
   end

   // item capture
   logic [15:0] rv_ff;
   logic        inv_ff;
   logic [11:0] idx_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rv_ff  <= req_range_value;
         inv_ff <= req_range_invalid;
         idx_ff <= req_sample_index;
      end
   end

   assign status.in_bounds = !inv_ff && rv_ff > range_lower_ff && rv_ff < range_upper_ff;

   // angle and rotation
   logic [27:0]        prod_a;
   logic [15:0]        angle;
   logic [1:0]         quad_ff;
   logic signed [33:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic [4:0]         step_ff;
   logic signed [33:0] xs, ys, at;

   assign prod_a = 28'($signed({1'b0, idx_ff}) * $signed(angle_step_ff));
   assign angle  = angle_start_ff + prod_a[15:0];
   assign xs     = x_ff >>> step_ff;
   assign ys     = y_ff >>> step_ff;
   assign at     = $signed({2'b00, atan_lut(step_ff)});

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      if (!z_ff[33]) begin
         x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
      end else begin
         x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cordic_init) begin
         quad_ff <= angle[15:14];
         x_ff    <= $signed({2'b00, CORDIC_INV_GAIN});
         y_ff    <= '0;
         z_ff    <= $signed({4'b0, angle[13:0], 16'b0});
         step_ff <= '0;
      end else if (cmd.cordic_step) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         step_ff <= step_ff + 1'b1;
      end
   end
   assign status.cordic_last = (step_ff == 5'(CORDIC_STEPS - 1));

   function automatic logic signed [16:0] sat15(input logic signed [33:0] v);
      logic signed [18:0] t;
      t = v[33:15];
      if (t > 19'sd32767) return 17'sd32767;
      if (t < -19'sd32768) return -17'sd32768;
      return t[16:0];
   endfunction

   logic signed [16:0] cx, sy, c, s;
   assign cx = sat15(x_ff);
   assign sy = sat15(y_ff);
   always_comb begin
      unique case (quad_ff)
         2'd0: begin c = cx;  s = sy;  end
         2'd1: begin c = -sy; s = cx;  end
         2'd2: begin c = -cx; s = -sy; end
         default: begin c = sy; s = -cx; end
      endcase
   end

   logic signed [33:0] mx, my;
   logic signed [18:0] rx_ff, ry_ff;
   assign mx = $signed({1'b0, rv_ff}) * c;
   assign my = $signed({1'b0, rv_ff}) * s;
   always_ff @(posedge clock) begin
      if (cmd.project) begin
         rx_ff <= mx[33:15];
         ry_ff <= my[33:15];
      end
   end

   // distance scan: read address is the next scan index, so the registered read lines up with scan_ff
   always_comb begin
      scan_in = scan_ff;
      if (cmd.project) scan_in = '0;
      else if (cmd.scan_step) scan_in = scan_ff + 1'b1;
   end
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
   end
   assign status.scan_empty = (count_ff == '0);
   assign status.scan_last  = (scan_ff + 1'b1 >= count_ff);

   logic signed [19:0] dx, dy;
   logic signed [39:0] dx2, dy2;
   logic [39:0]        d2;
   logic [31:0]        r2;
   logic               hit_ff;
   assign dx  = 20'(rx_ff) - 20'(px_rd_ff);
   assign dy  = 20'(ry_ff) - 20'(py_rd_ff);
   assign dx2 = dx * dx;
   assign dy2 = dy * dy;
   assign d2  = $unsigned(dx2) + $unsigned(dy2);
   assign r2  = mask_radius_ff * mask_radius_ff;

   always_ff @(posedge clock) begin
      if (cmd.project) hit_ff <= 1'b0;
      else if (cmd.scan_step && d2 < 40'(r2)) hit_ff <= 1'b1;
      else if (cmd.angle) hit_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_masked            <= hit_ff;
         rsp_range_out         <= hit_ff ? range_upper_ff : rv_ff;
         rsp_range_invalid_out <= inv_ff;
         rsp_sample_index_out  <= idx_ff;
      end
   end
endmodule
